>>> design/mcio_pkg.sv
`timescale 1ns / 1ps

package mcio_pkg;

    // scroll window size per page, default
    localparam int SCROLL_BYTES_DEF = 64;

    // access kinds carried in tuser
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam logic CFG_DIP_A = 1'b0;
    localparam logic CFG_DIP_B = 1'b1;

    // dip switch reset values
    localparam logic [7:0] DIP_A_RST = 8'hff;
    localparam logic [7:0] DIP_B_RST = 8'h60;

    // bus addresses
    localparam logic [15:0] CTRL_MASK     = 16'hfff8;
    localparam logic [15:0] SCROLL_BASE   = 16'h0020;
    localparam logic [15:0] MUL_LO_ADDR   = 16'h0200;
    localparam logic [15:0] MUL_HI_ADDR   = 16'h0201;
    localparam logic [15:0] PORT0_ADDR    = 16'h0400;
    localparam logic [15:0] DIP_A_ADDR    = 16'h0401;
    localparam logic [15:0] DIP_B_ADDR    = 16'h0402;
    localparam logic [15:0] PORT2_ADDR    = 16'h0403;
    localparam logic [15:0] PORT1_ADDR    = 16'h0404;
    localparam logic [15:0] TILE_ADDR     = 16'h040c;
    localparam logic [15:0] BANK_ADDR     = 16'h0410;
    localparam logic [15:0] SOUND_ADDR    = 16'h0414;
    localparam logic [15:0] SND_IRQ_ADDR  = 16'h0418;
    localparam logic [15:0] WDOG_ADDR     = 16'h041c;

    // controller register that triggers a sprite copy
    localparam logic [2:0] CTRL_SPR_REG = 3'd3;

    // sprite copy request codes
    localparam logic [1:0] SPR_NONE  = 2'd0;
    localparam logic [1:0] SPR_UPPER = 2'd1;
    localparam logic [1:0] SPR_LOWER = 2'd2;

    // decoded access, everything but the scroll byte itself
    typedef struct packed {
        logic [7:0] rd_data;
        logic       scroll_rd;
        logic [3:0] rom_bank;
        logic       video_page;
        logic       priority_mode;
        logic [7:0] tile_bank;
        logic [7:0] sound_cmd;
        logic       snd_irq;
        logic       wdog_kick;
        logic       ctrl_strobe;
        logic [2:0] ctrl_index;
        logic [7:0] ctrl_value;
        logic [1:0] sprite_copy;
    } t_dec;

    // scroll memory port controls
    typedef struct packed {
        logic wr;
        logic rd;
    } t_scr_cmd;

    // rom bank from the bank register
    function automatic logic [3:0] f_rom_bank(input logic [7:0] b);
        logic [3:0] bank;
        if (b[4]) begin
            bank = {1'b0, b[3:1]};
        end else begin
            bank = {3'b100, b[0]};
        end
        return bank;
    endfunction

endpackage

>>> design/mcio_scroll_ram.sv
`timescale 1ns / 1ps

module mcio_scroll_ram #(
    parameter int SCROLL_BYTES = 64,
    localparam int DEPTH = 2 * SCROLL_BYTES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcio_pkg::t_scr_cmd i_cmd,
    input  logic [AW-1:0]     i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);
    import mcio_pkg::*;

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [7:0]       r_q;
    logic             r_q_vld;

    // byte storage, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_cmd.rd) begin
            r_q <= r_mem[i_addr];
        end
    end

    // per-entry valid bits stand in for the cleared reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_q_vld <= r_valid[i_addr];
            end
        end
    end

    // never-written entries read as zero
    assign o_rdata = r_q_vld ? r_q : 8'h00;

endmodule

>>> design/mcio_regs.sv
`timescale 1ns / 1ps

module mcio_regs #(
    parameter int SCROLL_BYTES = 64,
    localparam int AW = $clog2(2 * SCROLL_BYTES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_accept,
    input  logic               i_opcode,
    input  logic [15:0]        i_address,
    input  logic [7:0]         i_write_data,
    input  logic [7:0]         i_port0,
    input  logic [7:0]         i_port1,
    input  logic [7:0]         i_port2,
    output mcio_pkg::t_dec     o_dec,
    output mcio_pkg::t_scr_cmd o_scr_cmd,
    output logic [AW-1:0]      o_scr_addr
);
    import mcio_pkg::*;

    localparam logic [15:0] SCROLL_LEN = 16'(SCROLL_BYTES);
    localparam logic [AW-1:0] PAGE_OFS = AW'(SCROLL_BYTES);

    logic [7:0] r_dip_a, r_dip_b;
    logic [7:0] r_op_a, r_op_b;
    logic [7:0] r_bank, r_tile, r_sound;
    logic [7:0] n_op_a, n_op_b;
    logic [7:0] n_bank, n_tile, n_sound;

    logic        is_wr;
    logic        is_ctrl;
    logic [15:0] scr_off;
    logic        in_scroll;
    logic [15:0] prod;
    logic [7:0]  rd_data;
    logic        snd_irq, wdog;

    // dip switch registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_a <= DIP_A_RST;
            r_dip_b <= DIP_B_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DIP_A: r_dip_a <= i_cfg_wr_data;
                CFG_DIP_B: r_dip_b <= i_cfg_wr_data;
                default:   r_dip_a <= r_dip_a;
            endcase
        end
    end

    // address decode
    assign is_wr     = (i_opcode == OP_WRITE);
    assign is_ctrl   = ((i_address & CTRL_MASK) == 16'h0000);
    assign scr_off   = i_address - SCROLL_BASE;
    assign in_scroll = (i_address >= SCROLL_BASE) && (scr_off < SCROLL_LEN);
    assign prod      = 16'(r_op_a) * 16'(r_op_b);

    // register writes and read mux
    always_comb begin
        n_op_a  = r_op_a;
        n_op_b  = r_op_b;
        n_bank  = r_bank;
        n_tile  = r_tile;
        n_sound = r_sound;
        snd_irq = 1'b0;
        wdog    = 1'b0;
        rd_data = 8'h00;
        if (is_wr) begin
            if (!is_ctrl && !in_scroll) begin
                unique case (i_address)
                    MUL_LO_ADDR:  n_op_a  = i_write_data;
                    MUL_HI_ADDR:  n_op_b  = i_write_data;
                    TILE_ADDR:    n_tile  = i_write_data;
                    BANK_ADDR:    n_bank  = i_write_data;
                    SOUND_ADDR:   n_sound = i_write_data;
                    SND_IRQ_ADDR: snd_irq = 1'b1;
                    WDOG_ADDR:    wdog    = 1'b1;
                    default:      ;
                endcase
            end
        end else begin
            unique case (i_address)
                MUL_LO_ADDR: rd_data = prod[7:0];
                MUL_HI_ADDR: rd_data = prod[15:8];
                PORT0_ADDR:  rd_data = i_port0;
                DIP_A_ADDR:  rd_data = r_dip_a;
                DIP_B_ADDR:  rd_data = r_dip_b;
                PORT2_ADDR:  rd_data = i_port2;
                PORT1_ADDR:  rd_data = i_port1;
                default:     rd_data = 8'h00;
            endcase
        end
    end

    // state registers advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_a  <= 8'h00;
            r_op_b  <= 8'h00;
            r_bank  <= 8'h00;
            r_tile  <= 8'h00;
            r_sound <= 8'h00;
        end else if (i_accept) begin
            r_op_a  <= n_op_a;
            r_op_b  <= n_op_b;
            r_bank  <= n_bank;
            r_tile  <= n_tile;
            r_sound <= n_sound;
        end
    end

    // scroll memory access on the current page
    assign o_scr_cmd.wr = i_accept && is_wr && in_scroll;
    assign o_scr_cmd.rd = i_accept && !is_wr && in_scroll;
    assign o_scr_addr   = (r_bank[6] ? PAGE_OFS : '0) + scr_off[AW-1:0];

    // decoded result, register fields show the state after the access
    always_comb begin
        o_dec               = '0;
        o_dec.rd_data       = rd_data;
        o_dec.scroll_rd     = !is_wr && in_scroll;
        o_dec.rom_bank      = f_rom_bank(n_bank);
        o_dec.video_page    = n_bank[6];
        o_dec.priority_mode = n_bank[5];
        o_dec.tile_bank     = n_tile;
        o_dec.sound_cmd     = n_sound;
        o_dec.snd_irq       = snd_irq;
        o_dec.wdog_kick     = wdog;
        o_dec.sprite_copy   = SPR_NONE;
        if (is_wr && is_ctrl) begin
            o_dec.ctrl_strobe = 1'b1;
            o_dec.ctrl_index  = i_address[2:0];
            o_dec.ctrl_value  = i_write_data;
            if (i_address[2:0] == CTRL_SPR_REG) begin
                o_dec.sprite_copy = i_write_data[3] ? SPR_LOWER : SPR_UPPER;
            end
        end
    end

endmodule

>>> design/main_cpu_io_decoder.sv
`timescale 1ns / 1ps

// Main CPU I/O decoder: one bus access per input transfer, one result per access.
// A transfer is accepted every clock cycle unless the output stalls; the decode
// and scroll memory read sit in the first register stage, the output register in
// the second, and the output register lets a new access in while a result waits.
// The scroll store (2 x SCROLL_BYTES bytes) reads as zero after reset through one
// valid flip-flop per entry, so no clearing pass is needed and input is taken
// right out of reset. The user writes DIP switch values through the config port
// (index 0 bank A, index 1 bank B) while the bus is idle; it is not enforced.
module main_cpu_io_decoder #(
    parameter int SCROLL_BYTES = mcio_pkg::SCROLL_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wr_data,
    // bus access stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // address[15:0], write_data[23:16], input_port_0[31:24],
    // input_port_1[39:32], input_port_2[47:40]
    input  logic [47:0] s_axis_tdata,
    // opcode[0]
    input  logic [0:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], rom_bank[11:8], video_page[12], priority_mode[13],
    // tile_bank_select[21:14], sound_command[29:22], sound_irq_pulse[30],
    // watchdog_kick[31], ctrl_write_strobe[32], ctrl_reg_index[35:33],
    // ctrl_write_value[43:36], sprite_copy[45:44], zero[47:46]
    output logic [47:0] m_axis_tdata
);
    import mcio_pkg::*;

    localparam int AW = $clog2(2 * SCROLL_BYTES);

    logic          accept;
    logic          s1_adv;
    t_dec          dec;
    t_scr_cmd      scr_cmd;
    logic [AW-1:0] scr_addr;
    logic [7:0]    scr_rdata;

    logic       r_s1_vld, n_s1_vld;
    t_dec       r_s1;
    logic       r_out_vld, n_out_vld;
    t_dec       r_out;
    t_dec       s1_final;

    // flow control
    assign s_axis_tready = !r_s1_vld || !r_out_vld || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s1_adv        = r_s1_vld && (!r_out_vld || m_axis_tready);

    // decode and architectural state
    mcio_regs #(
        .SCROLL_BYTES(SCROLL_BYTES)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (accept),
        .i_opcode     (s_axis_tuser[0]),
        .i_address    (s_axis_tdata[15:0]),
        .i_write_data (s_axis_tdata[23:16]),
        .i_port0      (s_axis_tdata[31:24]),
        .i_port1      (s_axis_tdata[39:32]),
        .i_port2      (s_axis_tdata[47:40]),
        .o_dec        (dec),
        .o_scr_cmd    (scr_cmd),
        .o_scr_addr   (scr_addr)
    );

    // scroll byte store
    mcio_scroll_ram #(
        .SCROLL_BYTES(SCROLL_BYTES)
    ) u_scroll (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (scr_cmd),
        .i_addr (scr_addr),
        .i_wdata(s_axis_tdata[23:16]),
        .o_rdata(scr_rdata)
    );

    // stage valid bits
    always_comb begin
        n_s1_vld  = accept ? 1'b1 : (s1_adv ? 1'b0 : r_s1_vld);
        n_out_vld = s1_adv ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // merge the scroll byte into the decoded result
    always_comb begin
        s1_final = r_s1;
        if (r_s1.scroll_rd) begin
            s1_final.rd_data = scr_rdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= dec;
        end
        if (s1_adv) begin
            r_out <= s1_final;
        end
    end

    // output packing
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00,
                            r_out.sprite_copy,
                            r_out.ctrl_value,
                            r_out.ctrl_index,
                            r_out.ctrl_strobe,
                            r_out.wdog_kick,
                            r_out.snd_irq,
                            r_out.sound_cmd,
                            r_out.tile_bank,
                            r_out.priority_mode,
                            r_out.video_page,
                            r_out.rom_bank,
                            r_out.rd_data};

    // sprite copy only comes with a write to its controller register
    a_spr_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.sprite_copy != SPR_NONE)
            |-> r_out.ctrl_strobe && (r_out.ctrl_index == CTRL_SPR_REG))
        else $error("sprite copy without controller write");

    // at most one write side effect per access
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $countones({r_out.ctrl_strobe, r_out.snd_irq, r_out.wdog_kick}) <= 1)
        else $error("several write strobes in one result");

    // read data only from reads
    a_rd_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && (r_out.rd_data != 8'h00)
            |-> !r_out.ctrl_strobe && !r_out.snd_irq && !r_out.wdog_kick)
        else $error("read data on a write");

    // forwarded controller fields stay zero without the strobe
    a_ctrl_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.ctrl_strobe
            |-> (r_out.ctrl_index == 3'd0) && (r_out.ctrl_value == 8'h00))
        else $error("controller fields without strobe");

    // a pending decode moves into a free output register
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !r_out_vld |=> r_out_vld)
        else $error("decode stage did not advance");

endmodule

>>> tb/main_cpu_io_decoder_test.sv
`timescale 1ns / 1ps

module main_cpu_io_decoder_test;
    import mcio_pkg::*;

    localparam int SCROLL_SIZE = SCROLL_BYTES_DEF;
    localparam logic [15:0] SCROLL_LAST = 16'(SCROLL_BASE + SCROLL_SIZE - 1);
    // addresses that decode to nothing
    localparam logic [15:0] NOMAP_MUL_ADDR = 16'h0206;
    localparam logic [15:0] NOMAP_IO_ADDR  = 16'h0408;
    localparam logic [15:0] TOP_ADDR       = 16'hffff;
    localparam int DRAIN_LIMIT = 20000;
    localparam int PHASE_ITEMS = 155;

    // expected fields of one result transfer
    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] rom_bank;
        logic       video_page;
        logic       priority_mode;
        logic [7:0] tile_bank_select;
        logic [7:0] sound_command;
        logic       sound_irq_pulse;
        logic       watchdog_kick;
        logic       ctrl_write_strobe;
        logic [2:0] ctrl_reg_index;
        logic [7:0] ctrl_write_value;
        logic [1:0] sprite_copy;
    } t_access_result;

    // receiver stall patterns
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_LONG} t_rx_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // address[15:0], write_data[23:16], input_port_0[31:24],
    // input_port_1[39:32], input_port_2[47:40]
    logic [47:0] s_axis_tdata;
    // opcode[0]
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // read_data[7:0], rom_bank[11:8], video_page[12], priority_mode[13],
    // tile_bank_select[21:14], sound_command[29:22], sound_irq_pulse[30],
    // watchdog_kick[31], ctrl_write_strobe[32], ctrl_reg_index[35:33],
    // ctrl_write_value[43:36], sprite_copy[45:44], zero[47:46]
    logic [47:0] m_axis_tdata;

    // decoder state as the predictor sees it
    logic [7:0] dip_a;
    logic [7:0] dip_b;
    logic [7:0] mul_a;
    logic [7:0] mul_b;
    logic [7:0] bank_reg;
    logic [7:0] tile_reg;
    logic [7:0] sound_reg;
    logic [7:0] scroll_mem [2*SCROLL_SIZE];

    t_access_result pending_results[$];

    int       error_count;
    int       reads_sent;
    int       writes_sent;
    int       dip_writes;
    int       results_checked;
    bit       sender_gaps;
    int       burst_left;
    t_rx_mode rx_mode;
    int       rx_count;
    int       rx_stall_left;

    main_cpu_io_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // work out the result of one accepted access and queue it
    task automatic predict_access(input logic op, input logic [15:0] addr,
                                  input logic [7:0] wd, input logic [7:0] p0,
                                  input logic [7:0] p1, input logic [7:0] p2);
        t_access_result res;
        logic [15:0]    product;
        logic           in_window;
        int             slot;
        res       = '0;
        product   = 16'(mul_a) * 16'(mul_b);
        in_window = (addr >= SCROLL_BASE) && (addr <= SCROLL_LAST);
        slot      = int'(bank_reg[6]) * SCROLL_SIZE + (int'(addr) - int'(SCROLL_BASE));
        if (op == OP_WRITE) begin
            if ((addr & CTRL_MASK) == 16'h0000) begin
                res.ctrl_write_strobe = 1'b1;
                res.ctrl_reg_index    = addr[2:0];
                res.ctrl_write_value  = wd;
                if (addr[2:0] == CTRL_SPR_REG) begin
                    res.sprite_copy = wd[3] ? SPR_LOWER : SPR_UPPER;
                end
            end else if (in_window) begin
                scroll_mem[slot] = wd;
            end else begin
                case (addr)
                    MUL_LO_ADDR:  mul_a = wd;
                    MUL_HI_ADDR:  mul_b = wd;
                    TILE_ADDR:    tile_reg = wd;
                    BANK_ADDR:    bank_reg = wd;
                    SOUND_ADDR:   sound_reg = wd;
                    SND_IRQ_ADDR: res.sound_irq_pulse = 1'b1;
                    WDOG_ADDR:    res.watchdog_kick = 1'b1;
                    default: ;
                endcase
            end
        end else if (in_window) begin
            res.read_data = scroll_mem[slot];
        end else begin
            case (addr)
                MUL_LO_ADDR: res.read_data = product[7:0];
                MUL_HI_ADDR: res.read_data = product[15:8];
                PORT0_ADDR:  res.read_data = p0;
                DIP_A_ADDR:  res.read_data = dip_a;
                DIP_B_ADDR:  res.read_data = dip_b;
                PORT2_ADDR:  res.read_data = p2;
                PORT1_ADDR:  res.read_data = p1;
                default:     res.read_data = 8'h00;
            endcase
        end
        // register views after the access
        res.rom_bank         = bank_reg[4] ? {1'b0, bank_reg[3:1]} : {3'b100, bank_reg[0]};
        res.video_page       = bank_reg[6];
        res.priority_mode    = bank_reg[5];
        res.tile_bank_select = tile_reg;
        res.sound_command    = sound_reg;
        pending_results.push_back(res);
    endtask

    // send one bus access, with the burst and gap pattern of the sender
    task automatic send_access(input logic op, input logic [15:0] addr,
                               input logic [7:0] wd, input logic [7:0] p0,
                               input logic [7:0] p1, input logic [7:0] p2);
        int gap;
        gap = 0;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(0, 8);
            end
            burst_left--;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {p2, p1, p0, wd, addr};
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_access(op, addr, wd, p0, p1, p2);
        if (op == OP_WRITE) writes_sent++;
        else reads_sent++;
    endtask

    task automatic send_read(input logic [15:0] addr);
        send_access(OP_READ, addr, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_write(input logic [15:0] addr, input logic [7:0] wd);
        send_access(OP_WRITE, addr, wd, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // hold the sender until every result is back and the pipe is empty
    task automatic wait_for_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > DRAIN_LIMIT) begin
                $display("results stopped with %0d outstanding", pending_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_dip(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_index   = idx;
        i_cfg_wr_data = val;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        if (idx == CFG_DIP_A) dip_a = val;
        else dip_b = val;
        dip_writes++;
    endtask

    // address mix weighted toward the decoded map
    function automatic logic [15:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) return 16'($urandom_range(0, 7));
        if (r < 38) return SCROLL_BASE + 16'($urandom_range(0, SCROLL_SIZE - 1));
        if (r < 48) return $urandom_range(0, 1) ? MUL_HI_ADDR : MUL_LO_ADDR;
        if (r < 62) return PORT0_ADDR + 16'($urandom_range(0, 4));
        if (r < 78) begin
            case ($urandom_range(0, 4))
                0: return TILE_ADDR;
                1: return BANK_ADDR;
                2: return SOUND_ADDR;
                3: return SND_IRQ_ADDR;
                default: return WDOG_ADDR;
            endcase
        end
        if (r < 90) begin
            // just outside the decoded ranges
            case ($urandom_range(0, 6))
                0: return SCROLL_BASE - 16'd1;
                1: return SCROLL_LAST + 16'd1;
                2: return MUL_HI_ADDR + 16'd1;
                3: return NOMAP_MUL_ADDR;
                4: return PORT1_ADDR + 16'd1;
                5: return NOMAP_IO_ADDR;
                default: return WDOG_ADDR + 16'($urandom_range(1, 3));
            endcase
        end
        return 16'($urandom);
    endfunction

    // receiver ready pattern
    always @(negedge i_clk) begin
        rx_count++;
        case (rx_mode)
            RX_ALWAYS:  m_axis_tready = 1'b1;
            RX_RANDOM:  m_axis_tready = 1'($urandom_range(0, 1));
            RX_PATTERN: m_axis_tready = (rx_count % 7) < 4;
            default: begin
                if (rx_stall_left > 0) begin
                    m_axis_tready = 1'b0;
                    rx_stall_left--;
                end else begin
                    m_axis_tready = 1'b1;
                    if ($urandom_range(0, 15) == 0) rx_stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[15:0], 16'h0000);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_axis_tdata[7:0] !== want.read_data)
                    report_mismatch("read_data", 16'(m_axis_tdata[7:0]),
                                    16'(want.read_data));
                if (m_axis_tdata[11:8] !== want.rom_bank)
                    report_mismatch("rom_bank", 16'(m_axis_tdata[11:8]),
                                    16'(want.rom_bank));
                if (m_axis_tdata[12] !== want.video_page)
                    report_mismatch("video_page", 16'(m_axis_tdata[12]),
                                    16'(want.video_page));
                if (m_axis_tdata[13] !== want.priority_mode)
                    report_mismatch("priority_mode", 16'(m_axis_tdata[13]),
                                    16'(want.priority_mode));
                if (m_axis_tdata[21:14] !== want.tile_bank_select)
                    report_mismatch("tile_bank_select", 16'(m_axis_tdata[21:14]),
                                    16'(want.tile_bank_select));
                if (m_axis_tdata[29:22] !== want.sound_command)
                    report_mismatch("sound_command", 16'(m_axis_tdata[29:22]),
                                    16'(want.sound_command));
                if (m_axis_tdata[30] !== want.sound_irq_pulse)
                    report_mismatch("sound_irq_pulse", 16'(m_axis_tdata[30]),
                                    16'(want.sound_irq_pulse));
                if (m_axis_tdata[31] !== want.watchdog_kick)
                    report_mismatch("watchdog_kick", 16'(m_axis_tdata[31]),
                                    16'(want.watchdog_kick));
                if (m_axis_tdata[32] !== want.ctrl_write_strobe)
                    report_mismatch("ctrl_write_strobe", 16'(m_axis_tdata[32]),
                                    16'(want.ctrl_write_strobe));
                if (m_axis_tdata[35:33] !== want.ctrl_reg_index)
                    report_mismatch("ctrl_reg_index", 16'(m_axis_tdata[35:33]),
                                    16'(want.ctrl_reg_index));
                if (m_axis_tdata[43:36] !== want.ctrl_write_value)
                    report_mismatch("ctrl_write_value", 16'(m_axis_tdata[43:36]),
                                    16'(want.ctrl_write_value));
                if (m_axis_tdata[45:44] !== want.sprite_copy)
                    report_mismatch("sprite_copy", 16'(m_axis_tdata[45:44]),
                                    16'(want.sprite_copy));
                if (m_axis_tdata[47:46] !== 2'b00)
                    report_mismatch("padding", 16'(m_axis_tdata[47:46]), 16'h0000);
            end
        end
    end

    // reset defaults of the dip banks and the register views
    task automatic test_reset_state();
        send_read(DIP_A_ADDR);
        send_read(DIP_B_ADDR);
        send_read(SCROLL_BASE);
        send_read(16'h0000);
        wait_for_results();
    endtask

    // port, multiplier, controller, tile, sound, irq, watchdog and unmapped addresses, field extremes
    task automatic test_decode_map();
        send_access(OP_READ, PORT0_ADDR, 8'h00, 8'h00, 8'hff, 8'hff);
        send_access(OP_READ, PORT1_ADDR, 8'hff, 8'hff, 8'ha5, 8'h00);
        send_access(OP_READ, PORT2_ADDR, 8'h00, 8'h00, 8'h00, 8'hff);
        send_write(MUL_LO_ADDR, 8'hff);
        send_write(MUL_HI_ADDR, 8'hff);
        send_read(MUL_LO_ADDR);
        send_read(MUL_HI_ADDR);
        send_write(16'h0000, 8'hff);
        send_write(16'h0003, 8'h00);
        send_write(16'h0003, 8'h08);
        send_write(16'h0007, 8'h5a);
        send_read(16'h0003);
        send_write(TILE_ADDR, 8'hff);
        send_write(SOUND_ADDR, 8'hff);
        send_write(SND_IRQ_ADDR, 8'h00);
        send_write(WDOG_ADDR, 8'h00);
        send_write(NOMAP_MUL_ADDR, 8'hff);
        send_write(NOMAP_IO_ADDR, 8'hff);
        send_read(TOP_ADDR);
        send_write(TOP_ADDR, 8'hff);
        wait_for_results();
    endtask

    // scroll window edges, both pages, rom bank and priority bits
    task automatic test_scroll_pages();
        rx_mode = RX_PATTERN;
        send_write(SCROLL_BASE, 8'h11);
        send_write(SCROLL_LAST, 8'h22);
        send_write(BANK_ADDR, 8'h41);
        send_read(SCROLL_BASE);
        send_write(SCROLL_BASE, 8'h33);
        send_read(SCROLL_BASE);
        send_write(BANK_ADDR, 8'h3e);
        send_read(SCROLL_BASE);
        send_read(SCROLL_LAST);
        send_read(SCROLL_BASE - 16'd1);
        send_write(SCROLL_LAST + 16'd1, 8'hff);
        send_write(BANK_ADDR, 8'hff);
        send_read(SCROLL_BASE);
        wait_for_results();
    endtask

    // dip banks at their extremes
    task automatic test_dip_switches();
        write_dip(CFG_DIP_A, 8'h00);
        write_dip(CFG_DIP_B, 8'hff);
        send_read(DIP_A_ADDR);
        send_read(DIP_B_ADDR);
        wait_for_results();
        write_dip(CFG_DIP_A, 8'hff);
        write_dip(CFG_DIP_B, 8'h00);
        send_read(DIP_A_ADDR);
        send_read(DIP_B_ADDR);
        wait_for_results();
    endtask

    // random accesses in phases, each setting its flow control and dip values
    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_dip(CFG_DIP_A, 8'h00);
                    write_dip(CFG_DIP_B, 8'h00);
                end
                1: begin
                    write_dip(CFG_DIP_A, 8'hff);
                    write_dip(CFG_DIP_B, 8'hff);
                end
                default: begin
                    write_dip(CFG_DIP_A, 8'($urandom));
                    write_dip(CFG_DIP_B, 8'($urandom));
                end
            endcase
            sender_gaps = (phase % 3) != 0;
            rx_mode     = t_rx_mode'(phase % 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_access(1'($urandom_range(0, 1)), pick_address(), 8'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom));
            end
            wait_for_results();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_DIP_A;
        i_cfg_wr_data   = 8'h00;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = OP_READ;
        m_axis_tready   = 1'b1;
        rx_mode         = RX_ALWAYS;
        rx_count        = 0;
        rx_stall_left   = 0;
        sender_gaps     = 1'b0;
        burst_left      = 0;
        error_count     = 0;
        reads_sent      = 0;
        writes_sent     = 0;
        dip_writes      = 0;
        results_checked = 0;
        dip_a           = DIP_A_RST;
        dip_b           = DIP_B_RST;
        mul_a           = 8'h00;
        mul_b           = 8'h00;
        bank_reg        = 8'h00;
        tile_reg        = 8'h00;
        sound_reg       = 8'h00;
        foreach (scroll_mem[k]) scroll_mem[k] = 8'h00;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_decode_map();
        test_scroll_pages();
        test_dip_switches();
        test_random_traffic();
        wait_for_results();
        repeat (8) @(negedge i_clk);

        $display("bus accesses: %0d reads, %0d writes, %0d dip bank writes",
                 reads_sent, writes_sent, dip_writes);
        $display("results checked: %0d, mismatches: %0d", results_checked, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
